// ===== rtl/bci_pkg.sv =====
package bci_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDXW       = $clog2(MAX_POINTS);
	localparam int CNTW       = $clog2(MAX_POINTS + 1);
	localparam int NSTEP      = 33;
	localparam int STEPW      = $clog2(NSTEP + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_STATUS = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_SCAN,
		S_INS_ADD,
		S_QRY_SCAN,
		S_MUL_INIT,
		S_MUL,
		S_DIV_INIT,
		S_DIV,
		S_QRY_FIN,
		S_MAX,
		S_OUT
	} state_t;

	typedef struct packed {
		logic            load_in;
		logic            clr;
		logic            ins_cmp;
		logic            ins_over;
		logic            ins_add;
		logic            set_full;
		logic            set_empty;
		logic            qry_cmp;
		logic            qry_clamp;
		logic            mul_init;
		logic            mul_step;
		logic            div_init;
		logic            div_step;
		logic            qry_fin;
		logic            max_step;
		logic            out_load;
		logic [IDXW-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic above;
		logic last;
		logic cnt_zero;
		logic full;
	} sts_t;

endpackage

// ===== rtl/breakpoint_curve_interpolator_unit.sv =====
// Piecewise-linear curve table with up to 16 breakpoints. The time that an
// insert, status item or query takes grows with the number of stored points;
// a query's time is set by the serial scans over the table and by the
// shift-add multiply followed by the restoring divide that produce the
// interpolation fraction. One item is worked on at a time; a finished result
// waits in the output register while the next item is taken in.
module breakpoint_curve_interpolator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] point_position,
	input  logic signed [31:0] point_value,
	input  logic signed [39:0] query_position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] curve_value,
	output logic signed [31:0] max_value,
	output logic [4:0]         point_count,
	output logic [1:0]         status
);
	import bci_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bci_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.point_position (point_position),
		.point_value    (point_value),
		.query_position (query_position),
		.curve_value    (curve_value),
		.max_value      (max_value),
		.point_count    (point_count),
		.status         (status)
	);

endmodule

// ===== rtl/bci_ctrl.sv =====
module bci_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    opcode,
	output logic          out_valid,
	input  logic          out_stall,
	input  bci_pkg::sts_t sts,
	output bci_pkg::cmd_t cmd
);
	import bci_pkg::*;

	state_t           state_q, state_d;
	logic [IDXW-1:0]  idx_q;
	logic [STEPW-1:0] step_q;
	logic             idx_clr, idx_inc, step_clr, step_inc;
	logic             out_valid_q;
	logic             accept;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan index and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			step_q <= '0;
		end else begin
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (step_clr) begin
				step_q <= '0;
			end else if (step_inc) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// output valid: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.idx  = idx_q;
		idx_clr  = 1'b0;
		idx_inc  = 1'b0;
		step_clr = 1'b0;
		step_inc = 1'b0;
		case (state_q)
			S_IDLE: begin
				idx_clr = 1'b1;
				if (accept) begin
					cmd.load_in = 1'b1;
					case (op_t'(opcode))
						OP_INSERT: state_d = S_INS_SCAN;
						OP_QUERY:  state_d = S_QRY_SCAN;
						OP_CLEAR: begin
							cmd.clr = 1'b1;
							state_d = S_MAX;
						end
						default:   state_d = S_MAX;
					endcase
				end
			end
			S_INS_SCAN: begin
				if (sts.cnt_zero) begin
					state_d = S_INS_ADD;
				end else if (sts.hit) begin
					cmd.ins_over = 1'b1;
					idx_clr      = 1'b1;
					state_d      = S_MAX;
				end else begin
					cmd.ins_cmp = 1'b1;
					idx_inc     = 1'b1;
					if (sts.last) begin
						state_d = S_INS_ADD;
					end
				end
			end
			S_INS_ADD: begin
				idx_clr = 1'b1;
				if (sts.full) begin
					cmd.set_full = 1'b1;
				end else begin
					cmd.ins_add = 1'b1;
				end
				state_d = S_MAX;
			end
			S_QRY_SCAN: begin
				if (sts.cnt_zero) begin
					cmd.set_empty = 1'b1;
					idx_clr       = 1'b1;
					state_d       = S_MAX;
				end else begin
					cmd.qry_cmp = 1'b1;
					idx_inc     = 1'b1;
					if (sts.above && idx_q == '0) begin
						cmd.qry_clamp = 1'b1;
						idx_clr       = 1'b1;
						state_d       = S_MAX;
					end else if (sts.above) begin
						idx_clr = 1'b1;
						state_d = S_MUL_INIT;
					end else if (sts.last) begin
						cmd.qry_clamp = 1'b1;
						idx_clr       = 1'b1;
						state_d       = S_MAX;
					end
				end
			end
			S_MUL_INIT: begin
				cmd.mul_init = 1'b1;
				step_clr     = 1'b1;
				state_d      = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				step_inc     = 1'b1;
				if (step_q == STEPW'(NSTEP - 1)) begin
					state_d = S_DIV_INIT;
				end
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				step_clr     = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				step_inc     = 1'b1;
				if (step_q == STEPW'(NSTEP - 1)) begin
					state_d = S_QRY_FIN;
				end
			end
			S_QRY_FIN: begin
				cmd.qry_fin = 1'b1;
				idx_clr     = 1'b1;
				state_d     = S_MAX;
			end
			S_MAX: begin
				if (sts.cnt_zero) begin
					state_d = S_OUT;
				end else begin
					cmd.max_step = 1'b1;
					idx_inc      = 1'b1;
					if (sts.last) begin
						state_d = S_OUT;
					end
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted item did not start work");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_DIV) |-> step_q < STEPW'(NSTEP))
		else $error("step counter overran");
	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwritten before transfer");

endmodule

// ===== rtl/bci_dpath.sv =====
module bci_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  bci_pkg::cmd_t       cmd,
	output bci_pkg::sts_t       sts,
	input  logic signed [31:0]  point_position,
	input  logic signed [31:0]  point_value,
	input  logic signed [39:0]  query_position,
	output logic signed [31:0]  curve_value,
	output logic signed [31:0]  max_value,
	output logic [4:0]          point_count,
	output logic [1:0]          status
);
	import bci_pkg::*;

	logic signed [31:0] pos_q [MAX_POINTS];
	logic signed [31:0] val_q [MAX_POINTS];
	logic [CNTW-1:0]    count_q;
	logic [CNTW-1:0]    at_q;
	logic signed [31:0] ipos_q, ival_q;
	logic signed [39:0] qpos_q;
	logic signed [31:0] lo_pos_q, lo_val_q, hi_pos_q, hi_val_q;
	logic signed [31:0] curve_q, max_q;
	status_t            status_q;
	logic [32:0]        mag_q;
	logic               neg_q;
	logic [39:0]        f_q, d_q;
	logic [71:0]        acc_q;
	logic [39:0]        rem_q;
	logic [32:0]        quo_q;
	logic signed [31:0] out_curve_q, out_max_q;
	logic [4:0]         out_count_q;
	status_t            out_status_q;

	logic signed [31:0] cur_pos, cur_val;
	logic signed [39:0] cur_pos_s;
	logic signed [32:0] delta;
	logic [40:0]        trial, trial_sub;
	logic               ge;

	assign cur_pos   = pos_q[cmd.idx];
	assign cur_val   = val_q[cmd.idx];
	assign cur_pos_s = $signed({cur_pos, 8'b0});
	assign delta     = {hi_val_q[31], hi_val_q} - {lo_val_q[31], lo_val_q};
	assign trial     = {rem_q, quo_q[32]};
	assign trial_sub = trial - {1'b0, d_q};
	assign ge        = (trial >= {1'b0, d_q});

	// status toward the controller
	assign sts.hit      = (cur_pos == ipos_q);
	assign sts.above    = (cur_pos_s > qpos_q);
	assign sts.last     = ({1'b0, cmd.idx} == CNTW'(count_q - 1'b1));
	assign sts.cnt_zero = (count_q == '0);
	assign sts.full     = (count_q == CNTW'(MAX_POINTS));

	// point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr) begin
			count_q <= '0;
		end else if (cmd.ins_add) begin
			count_q <= count_q + 1'b1;
		end
	end

	// breakpoint table: overwrite in place or open a slot and shift up
	always_ff @(posedge clk) begin
		if (cmd.ins_over) begin
			val_q[cmd.idx] <= ival_q;
		end
		if (cmd.ins_add) begin
			for (int i = 0; i < MAX_POINTS; i++) begin
				if (CNTW'(i) == at_q) begin
					pos_q[i] <= ipos_q;
					val_q[i] <= ival_q;
				end
			end
			for (int i = 1; i < MAX_POINTS; i++) begin
				if (CNTW'(i) > at_q) begin
					pos_q[i] <= pos_q[i-1];
					val_q[i] <= val_q[i-1];
				end
			end
		end
	end

	// item capture, insert slot search, bracket search
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ipos_q   <= point_position;
			ival_q   <= point_value;
			qpos_q   <= query_position;
			at_q     <= '0;
			curve_q  <= '0;
			status_q <= ST_OK;
		end
		if (cmd.ins_cmp && cur_pos < ipos_q) begin
			at_q <= at_q + 1'b1;
		end
		if (cmd.set_full) begin
			status_q <= ST_FULL;
		end
		if (cmd.set_empty) begin
			status_q <= ST_EMPTY;
		end
		if (cmd.qry_cmp) begin
			if (sts.above) begin
				hi_pos_q <= cur_pos;
				hi_val_q <= cur_val;
			end else begin
				lo_pos_q <= cur_pos;
				lo_val_q <= cur_val;
			end
		end
		if (cmd.qry_clamp) begin
			curve_q <= cur_val;
		end
		if (cmd.qry_fin) begin
			curve_q <= neg_q ? lo_val_q - $signed(quo_q[31:0])
			                 : lo_val_q + $signed(quo_q[31:0]);
		end
		if (cmd.max_step && (cmd.idx == '0 || cur_val > max_q)) begin
			max_q <= cur_val;
		end
	end

	// shift-add multiply, then restoring divide, one bit a cycle
	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			neg_q <= delta[32];
			mag_q <= delta[32] ? 33'(-delta) : 33'(delta);
			f_q   <= 40'(qpos_q - $signed({lo_pos_q, 8'b0}));
			d_q   <= {32'(hi_pos_q - lo_pos_q), 8'b0};
			acc_q <= '0;
		end
		if (cmd.mul_step) begin
			acc_q <= {acc_q[70:0], 1'b0} + (mag_q[32] ? {32'b0, f_q} : 72'b0);
			mag_q <= {mag_q[31:0], 1'b0};
		end
		if (cmd.div_init) begin
			rem_q <= {1'b0, acc_q[71:33]};
			quo_q <= acc_q[32:0];
		end
		if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[39:0] : trial[39:0];
			quo_q <= {quo_q[31:0], ge};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_curve_q  <= curve_q;
			out_max_q    <= (count_q == '0) ? 32'sd0 : max_q;
			out_count_q  <= 5'(count_q);
			out_status_q <= status_q;
		end
	end

	assign curve_value = out_curve_q;
	assign max_value   = out_max_q;
	assign point_count = out_count_q;
	assign status      = out_status_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_POINTS))
		else $error("point count beyond table size");
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_full |-> count_q == CNTW'(MAX_POINTS))
		else $error("insert dropped while table not full");
	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_add |-> (count_q < CNTW'(MAX_POINTS) && at_q <= count_q))
		else $error("insert slot out of range");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bci_pkg::*;

	localparam int  TABLE_DEPTH = 16;
	localparam int  RANDOM_ITEMS = 600;
	localparam int  QUIET_TAIL = 60;
	localparam int  DRAIN_CYCLES = 150;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [31:0] curve;
		logic signed [31:0] peak;
		logic [4:0]         count;
		status_t            st;
	} curve_result_t;

	typedef struct {
		op_t                op;
		logic signed [31:0] ppos;
		logic signed [31:0] pval;
		logic signed [39:0] qpos;
		bit                 typed;
		curve_result_t      res;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic signed [31:0] point_position;
	logic signed [31:0] point_value;
	logic signed [39:0] query_position;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] curve_value;
	logic signed [31:0] max_value;
	logic [4:0]         point_count;
	logic [1:0]         status;

	breakpoint_curve_interpolator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .point_position(point_position),
		.point_value(point_value), .query_position(query_position),
		.out_valid(out_valid), .out_stall(out_stall),
		.curve_value(curve_value), .max_value(max_value),
		.point_count(point_count), .status(status)
	);

	// Shadow breakpoint table
	logic signed [31:0] bp_pos[TABLE_DEPTH];
	logic signed [31:0] bp_val[TABLE_DEPTH];
	int                 bp_count;

	curve_result_t      expected_results[$];
	stim_row_t          directed[$];
	longint             cycles;
	int                 mismatches;
	int                 checked;
	int                 op_seen[4];
	int                 drops_seen;
	int                 empty_seen;
	bit                 quiet;

	// Clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("breakpoint_curve_interpolator_unit verification failed");
			$finish;
		end
	end

	// Interpolate at a 40-bit position with 8 fraction bits
	function automatic logic signed [31:0] curve_at(logic signed [39:0] q);
		longint      qv, vl, vh, f, d, delta;
		int          lo_i;
		logic [127:0] prod, quot;
		qv = longint'(q);
		lo_i = 0;
		if (qv < longint'(bp_pos[0]) * 256)
			return bp_val[0];
		for (int i = 0; i < bp_count; i++)
			if (longint'(bp_pos[i]) * 256 <= qv)
				lo_i = i;
		if (lo_i + 1 >= bp_count)
			return bp_val[lo_i];
		vl = longint'(bp_val[lo_i]);
		vh = longint'(bp_val[lo_i + 1]);
		f = qv - longint'(bp_pos[lo_i]) * 256;
		d = (longint'(bp_pos[lo_i + 1]) - longint'(bp_pos[lo_i])) * 256;
		delta = vh - vl;
		prod = 128'(delta < 0 ? -delta : delta) * 128'(f);
		quot = prod / 128'(d);
		if (delta < 0)
			return 32'(vl - longint'(quot[63:0]));
		return 32'(vl + longint'(quot[63:0]));
	endfunction

	// Apply one transfer to the shadow table and return its result
	function automatic curve_result_t table_step(op_t op, logic signed [31:0] ppos,
			logic signed [31:0] pval, logic signed [39:0] qpos);
		curve_result_t r;
		bit            found;
		int            at;
		r.curve = '0;
		r.st = ST_OK;
		found = 0;
		case (op)
			OP_INSERT: begin
				for (int i = 0; i < bp_count; i++)
					if (!found && bp_pos[i] == ppos) begin
						bp_val[i] = pval;
						found = 1;
					end
				if (!found) begin
					if (bp_count >= TABLE_DEPTH) begin
						r.st = ST_FULL;
					end else begin
						at = 0;
						while (at < bp_count && bp_pos[at] < ppos)
							at++;
						for (int i = bp_count; i > at; i--) begin
							bp_pos[i] = bp_pos[i - 1];
							bp_val[i] = bp_val[i - 1];
						end
						bp_pos[at] = ppos;
						bp_val[at] = pval;
						bp_count++;
					end
				end
			end
			OP_QUERY: begin
				if (bp_count == 0)
					r.st = ST_EMPTY;
				else
					r.curve = curve_at(qpos);
			end
			OP_CLEAR: bp_count = 0;
			default: ;
		endcase
		r.peak = '0;
		for (int i = 0; i < bp_count; i++)
			if (i == 0 || bp_val[i] > r.peak)
				r.peak = bp_val[i];
		r.count = 5'(bp_count);
		return r;
	endfunction

	task automatic add_row(op_t op, logic signed [31:0] ppos, logic signed [31:0] pval,
			logic signed [39:0] qpos, bit typed = 0, logic signed [31:0] cv = 0,
			logic signed [31:0] mv = 0, int pc = 0, status_t st = ST_OK);
		stim_row_t row;
		row.op = op;
		row.ppos = ppos;
		row.pval = pval;
		row.qpos = qpos;
		row.typed = typed;
		row.res.curve = cv;
		row.res.peak = mv;
		row.res.count = 5'(pc);
		row.res.st = st;
		directed.push_back(row);
	endtask

	// Drive one item, hold it until the transfer, then record the expectation
	task automatic send(op_t op, logic signed [31:0] ppos, logic signed [31:0] pval,
			logic signed [39:0] qpos, bit typed = 0,
			curve_result_t typed_res = '{curve: '0, peak: '0, count: '0, st: ST_OK});
		curve_result_t r;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		point_position = ppos;
		point_value = pval;
		query_position = qpos;
		do
			@(posedge clk);
		while (in_stall);
		r = table_step(op, ppos, pval, qpos);
		expected_results.push_back(typed ? typed_res : r);
		op_seen[op]++;
		if (r.st == ST_FULL)
			drops_seen++;
		if (r.st == ST_EMPTY)
			empty_seen++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Query near or between stored points, or at a random position
	function automatic logic signed [39:0] near_query();
		int     i;
		longint base, span;
		if (bp_count == 0 || $urandom_range(0, 9) == 0)
			return {8'($urandom), 32'($urandom)};
		i = $urandom_range(0, bp_count - 1);
		base = longint'(bp_pos[i]) * 256;
		if (i + 1 < bp_count && $urandom_range(0, 3) != 0) begin
			span = (longint'(bp_pos[i + 1]) - longint'(bp_pos[i])) * 256;
			return 40'(base + span * $urandom_range(0, 1023) / 1024);
		end
		return 40'(base + longint'($urandom_range(0, 1024)) - 512);
	endfunction

	// Result stall in random bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && arst_n && $urandom_range(0, 9) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Compare every result transfer with the oldest expectation
	always @(posedge clk) begin
		curve_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: curve %0d max %0d count %0d status %0d",
						curve_value, max_value, point_count, status);
			end else begin
				e = expected_results.pop_front();
				checked++;
				if (curve_value !== e.curve || max_value !== e.peak ||
						point_count !== e.count || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch #%0d: exp curve %0d max %0d count %0d st %0d,",
							" got curve %0d max %0d count %0d st %0d"},
							checked, e.curve, e.peak, e.count, e.st,
							curve_value, max_value, point_count, status);
				end
			end
		end
	end

	initial begin
		int    items, n, k;
		bit    spread, paused;
		cycles = 0;
		mismatches = 0;
		checked = 0;
		drops_seen = 0;
		empty_seen = 0;
		quiet = 0;
		paused = 0;
		bp_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_STATUS;
		point_position = '0;
		point_value = '0;
		query_position = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed table: empty table, ends, extremes, overwrite, clear
		add_row(OP_STATUS, 0, 0, 0, 1, 0, 0, 0, ST_OK);
		add_row(OP_QUERY, 0, 0, 0, 1, 0, 0, 0, ST_EMPTY);
		add_row(OP_INSERT, 0, 32'sh0001_0000, 0, 1, 0, 32'sh0001_0000, 1, ST_OK);
		add_row(OP_INSERT, 10, 32'sh000A_0000, 0, 1, 0, 32'sh000A_0000, 2, ST_OK);
		add_row(OP_QUERY, 0, 0, 40'sd1280);
		add_row(OP_QUERY, 0, 0, 40'sh80_0000_0000, 1, 32'sh0001_0000, 32'sh000A_0000, 2);
		add_row(OP_QUERY, 0, 0, 40'sh7F_FFFF_FFFF, 1, 32'sh000A_0000, 32'sh000A_0000, 2);
		add_row(OP_QUERY, 0, 0, 40'sd2560, 1, 32'sh000A_0000, 32'sh000A_0000, 2);
		add_row(OP_QUERY, 0, 0, 40'sd1);
		add_row(OP_INSERT, 0, 32'sh8000_0000, 0, 1, 0, 32'sh000A_0000, 2, ST_OK);
		add_row(OP_QUERY, 0, 0, 40'sd777);
		add_row(OP_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, 0, 32'sh7FFF_FFFF, 3);
		add_row(OP_INSERT, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 0, 1, 0, 32'sh7FFF_FFFF, 4);
		add_row(OP_QUERY, 0, 0, -40'sd100);
		add_row(OP_QUERY, 0, 0, 40'sh3F_0000_0001);
		add_row(OP_QUERY, 0, 0, 40'sh7F_FFFF_FF00);
		add_row(OP_STATUS, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 40'shFF_FFFF_FFFF);
		add_row(OP_CLEAR, 0, 0, 0, 1, 0, 0, 0, ST_OK);
		add_row(OP_QUERY, 0, 0, 40'sd5, 1, 0, 0, 0, ST_EMPTY);
		add_row(OP_INSERT, -5, 32'sh8000_0000, 0, 1, 0, 32'sh8000_0000, 1);
		add_row(OP_QUERY, 0, 0, 40'sd9999, 1, 32'sh8000_0000, 32'sh8000_0000, 1);
		foreach (directed[i])
			send(directed[i].op, directed[i].ppos, directed[i].pval, directed[i].qpos,
				directed[i].typed, directed[i].res);

		// Fill past capacity so the drop flag fires
		send(OP_CLEAR, 0, 0, 0);
		for (int i = 0; i < TABLE_DEPTH + 2; i++)
			send(OP_INSERT, 3 * i - 20, 32'($urandom), 0);
		send(OP_INSERT, 1, 0, 0);
		send(OP_QUERY, 0, 0, near_query());

		// Random part: mostly clear/fill/query sequences, some noise
		items = 0;
		while (items < RANDOM_ITEMS) begin
			if (items >= RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1;
			if (!paused && items >= RANDOM_ITEMS / 2) begin
				wait (expected_results.size() == 0);
				paused = 1;
			end
			if ($urandom_range(0, 4) != 0) begin
				send(OP_CLEAR, 32'($urandom), 32'($urandom), {8'($urandom), 32'($urandom)});
				n = $urandom_range(1, 20);
				spread = $urandom_range(0, 2) == 0;
				for (int i = 0; i < n; i++)
					send(OP_INSERT,
						spread ? 32'($urandom) : 32'($urandom_range(0, 40)) - 32'sd20,
						$urandom_range(0, 3) == 0 ? 32'($urandom)
							: 32'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
						{8'($urandom), 32'($urandom)});
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++)
					send(OP_QUERY, 32'($urandom), 32'($urandom), near_query());
				items += n + k + 1;
			end else begin
				send(op_t'($urandom_range(0, 3)), 32'($urandom), 32'($urandom),
					{8'($urandom), 32'($urandom)});
				items++;
			end
		end

		// Drain
		quiet = 1;
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d inserts, %0d queries, %0d clears, %0d status items",
			op_seen[OP_INSERT], op_seen[OP_QUERY], op_seen[OP_CLEAR], op_seen[OP_STATUS]);
		$display("%0d results checked, full-table drops %0d, empty-table queries %0d, mismatches %0d",
			checked, drops_seen, empty_seen, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("breakpoint_curve_interpolator_unit verification clean");
		else
			$display("breakpoint_curve_interpolator_unit verification failed");
		$finish;
	end

endmodule
